### hw/rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list.
package pol_pkg;

	// Default number of entries the list can hold.
	localparam int DEF_CAPACITY = 16;

	// Command codes carried by the op field.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_DUMP      = 3'd6
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;    // capture the incoming word
		logic exec;     // carry out the captured command and load the first result
		logic advance;  // load the next dump result
	} pol_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;     // the loaded result is the final one of its command
	} pol_stat_t;

endpackage

### hw/rtl/pol_ctrl.sv
// Controller state machine for the positional ordered list.
module pol_ctrl import pol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output pol_cmd_t  cmd,
	input  pol_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (!stat.last) begin
						cmd.advance = 1'b1;
					end else begin
						// The final result leaves, so a new word may enter now.
						in_stall = 1'b0;
						if (in_valid) begin
							cmd.latch = 1'b1;
							state_d   = S_EXEC;
						end else begin
							state_d = S_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/pol_datapath.sv
// Datapath for the positional ordered list: entry array, count and result register.
module pol_datapath import pol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pol_cmd_t           cmd,
	output pol_stat_t          stat,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic signed [31:0] entry_value,
	output logic               entry_valid,
	output logic               last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	// Captured input word.
	op_t               op_q;
	logic signed [31:0] value_q;
	logic [4:0]        pos_q;

	// List state.
	logic signed [31:0] ent_q    [CAPACITY];
	logic signed [31:0] ent_d    [CAPACITY];
	logic signed [31:0] ent_prev [CAPACITY];
	logic signed [31:0] ent_next [CAPACITY];
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   dump_idx_q;

	// Result register.
	status_t            status_q;
	logic signed [31:0] entry_value_q;
	logic               entry_valid_q;
	logic               last_q;

	// Decoded command.
	logic              do_ins, do_del, do_rot, do_dump;
	logic [CMP_W-1:0]  idx;
	logic [CMP_W-1:0]  cnt_x, pos_x;
	logic              full, empty;
	status_t           st;

	assign cnt_x = CMP_W'(count_q);
	assign pos_x = CMP_W'(pos_q);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Work out what the captured command does to the list.
	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_dump = 1'b0;
		idx     = '0;
		st      = ST_OK;
		unique case (op_q) inside
			OP_INS_FRONT, OP_INS_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = (op_q == OP_INS_FRONT) ? '0 : cnt_x;
				end
			end
			OP_INS_POS: begin
				if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					st = ST_BADPOS;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = pos_x - CMP_W'(1);
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_del = 1'b1;
					idx    = (op_q == OP_DEL_FRONT) ? '0 : cnt_x - CMP_W'(1);
				end
			end
			OP_DEL_POS: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					st = ST_BADPOS;
				end else begin
					do_del = 1'b1;
					idx    = pos_x - CMP_W'(1);
				end
			end
			OP_DUMP: begin
				do_dump = !empty;
			end
			default: begin
			end
		endcase
	end

	// A dump rotates the held entries by one place for every entry it emits.
	assign do_rot = (cmd.exec && do_dump) || cmd.advance;

	// Neighbour taps of each entry; the ends tap themselves.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
		if (g == 0) begin : g_first
			assign ent_prev[g] = ent_q[g];
		end else begin : g_mid_prev
			assign ent_prev[g] = ent_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_final
			assign ent_next[g] = ent_q[g];
		end else begin : g_mid_next
			assign ent_next[g] = ent_q[g+1];
		end
	end

	// Next value of each entry for insert, delete and rotate.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ent_d[i] = ent_q[i];
			if (do_rot) begin
				if (CMP_W'(i) + CMP_W'(1) == cnt_x) begin
					ent_d[i] = ent_q[0];
				end else if (CMP_W'(i) + CMP_W'(1) < cnt_x) begin
					ent_d[i] = ent_next[i];
				end
			end else if (cmd.exec && do_ins) begin
				if (CMP_W'(i) == idx) begin
					ent_d[i] = value_q;
				end else if (CMP_W'(i) > idx && CMP_W'(i) <= cnt_x) begin
					ent_d[i] = ent_prev[i];
				end
			end else if (cmd.exec && do_del) begin
				if (CMP_W'(i) >= idx && CMP_W'(i) + CMP_W'(1) < cnt_x) begin
					ent_d[i] = ent_next[i];
				end
			end
		end
	end

	// Count after the command.
	always_comb begin
		count_d = count_q;
		if (cmd.exec && do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.exec && do_del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Entry array; its contents need no reset.
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.advance) begin
			ent_q <= ent_d;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Input capture, dump position and result register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op_t'(op);
			value_q <= value;
			pos_q   <= position;
		end
		if (cmd.exec) begin
			status_q      <= st;
			entry_value_q <= do_dump ? ent_q[0] : '0;
			entry_valid_q <= do_dump;
			last_q        <= do_dump ? (count_q == CNT_W'(1)) : 1'b1;
			dump_idx_q    <= CNT_W'(1);
		end else if (cmd.advance) begin
			status_q      <= ST_OK;
			entry_value_q <= ent_q[0];
			entry_valid_q <= 1'b1;
			last_q        <= (dump_idx_q + CNT_W'(1) == count_q);
			dump_idx_q    <= dump_idx_q + CNT_W'(1);
		end
	end

	assign stat.last   = last_q;
	assign status      = status_q;
	assign count       = 5'(count_q);
	assign entry_value = entry_value_q;
	assign entry_valid = entry_valid_q;
	assign last        = last_q;

endmodule

### hw/rtl/positional_ordered_list.sv
// Top level of the positional ordered list.
// Holds up to CAPACITY signed 32-bit entries in order and takes one command word at a time:
// insert or delete at the front, at the back or at a 1-based position, or dump. An update
// gives one result word: the word is first captured, then the entry registers shift and the
// result register is loaded. The next command word is taken in the same cycle that the final
// result word leaves, so a new command word is not taken while one is still in progress. A
// dump of N entries gives N result words, one per cycle while the output side does not stall,
// set by the rotation of the entry registers through the front entry; an empty dump gives
// one word with entry_valid low. The count field shows the count modulo 32.
module positional_ordered_list import pol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic signed [31:0] entry_value,
	output logic               entry_valid,
	output logic               last
);

	pol_cmd_t  cmd;
	pol_stat_t stat;

	// Sequencing of capture, execution and result delivery.
	pol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Entry registers, count and result register.
	pol_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.value       (value),
		.position    (position),
		.status      (status),
		.count       (count),
		.entry_value (entry_value),
		.entry_valid (entry_valid),
		.last        (last)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for the positional ordered list.
module tb;
	import pol_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;

	// Op code that the block does not use; it must answer with a plain status word.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// Extreme entry values.
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	// One expected result word.
	typedef struct {
		status_t            st;
		logic [4:0]         cnt;
		logic signed [31:0] ev;
		logic               evalid;
		logic               lst;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         op = 3'd0;
	logic signed [31:0] value = 32'sd0;
	logic [4:0]         position = 5'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [4:0]         count;
	logic signed [31:0] entry_value;
	logic               entry_valid;
	logic               last;

	// Predicted list contents, front first, and the result words still to come.
	logic signed [31:0] held_entries[$];
	list_result_t       pending_results[$];

	int  mismatches = 0;
	bit  send_idling = 1'b0;
	bit  stall_idling = 1'b0;
	int  stall_left = 0;

	positional_ordered_list #(.CAPACITY(CAPACITY)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.count      (count),
		.entry_value(entry_value),
		.entry_valid(entry_valid),
		.last       (last)
	);

	always #5 clk = ~clk;

	// Prints one line for a mismatch and counts it.
	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic queue_result(input status_t st, input logic signed [31:0] ev,
			input logic evalid, input logic lst);
		list_result_t r;
		r.st = st;
		r.cnt = 5'(held_entries.size());
		r.ev = ev;
		r.evalid = evalid;
		r.lst = lst;
		pending_results.push_back(r);
	endtask

	// Applies one accepted command to the predicted list and queues the words it gives.
	task automatic apply_list_command(input logic [2:0] code, input logic signed [31:0] val,
			input logic [4:0] pos);
		int n;
		status_t st;
		n = held_entries.size();
		st = ST_OK;
		if (code == OP_DUMP) begin
			if (n == 0)
				queue_result(ST_OK, 32'sd0, 1'b0, 1'b1);
			for (int i = 0; i < n; i++)
				queue_result(ST_OK, held_entries[i], 1'b1, i == n - 1);
		end else begin
			case (code)
				OP_INS_FRONT, OP_INS_BACK: begin
					if (n >= CAPACITY)
						st = ST_FULL;
					else if (code == OP_INS_FRONT)
						held_entries.push_front(val);
					else
						held_entries.push_back(val);
				end
				OP_INS_POS: begin
					// A bad position is reported ahead of a full list.
					if (pos < 1 || int'(pos) > n + 1)
						st = ST_BADPOS;
					else if (n >= CAPACITY)
						st = ST_FULL;
					else
						held_entries.insert(int'(pos) - 1, val);
				end
				OP_DEL_FRONT, OP_DEL_BACK: begin
					if (n == 0)
						st = ST_EMPTY;
					else if (code == OP_DEL_FRONT)
						held_entries.delete(0);
					else
						held_entries.delete(n - 1);
				end
				OP_DEL_POS: begin
					if (pos < 1 || int'(pos) > n)
						st = ST_BADPOS;
					else
						held_entries.delete(int'(pos) - 1);
				end
				default: ;
			endcase
			queue_result(st, 32'sd0, 1'b0, 1'b1);
		end
	endtask

	// Offers one command word, after an optional idle gap, and waits until it is taken.
	// Valid stays high on return so that a following word goes out without a bubble.
	task automatic issue_command(input logic [2:0] code, input logic signed [31:0] val,
			input logic [4:0] pos);
		if (send_idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		value <= val;
		position <= pos;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		apply_list_command(code, val, pos);
	endtask

	// The output side stalls in bursts of random length while enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_idling && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Each word taken from the output is checked against the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result word, count", count, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					flag_mismatch("status", status, want.st);
				if (count !== want.cnt)
					flag_mismatch("count", count, want.cnt);
				if (entry_value !== want.ev)
					flag_mismatch("entry_value", entry_value, want.ev);
				if (entry_valid !== want.evalid)
					flag_mismatch("entry_valid", entry_valid, want.evalid);
				if (last !== want.lst)
					flag_mismatch("last", last, want.lst);
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return ($urandom_range(0, 1) == 1) ? 32'sd0 : -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Dumps, deletes, position inserts and an unused op code against an empty list, including the bad positions.
	task automatic test_empty_list();
		issue_command(OP_DUMP, 32'sd0, 5'd0);
		issue_command(OP_DEL_FRONT, 32'sd0, 5'd0);
		issue_command(OP_DEL_BACK, 32'sd0, 5'd0);
		issue_command(OP_DEL_POS, 32'sd0, 5'd1);
		issue_command(OP_DEL_POS, 32'sd0, 5'd0);
		issue_command(OP_DEL_POS, 32'sd0, 5'd31);
		issue_command(OP_INS_POS, VAL_MAX, 5'd0);
		issue_command(OP_INS_POS, VAL_MAX, 5'd2);
		issue_command(OP_UNUSED, VAL_MIN, 5'd31);
	endtask

	// Inserts and deletes at the front, the back and in the middle of a short list.
	task automatic test_middle_updates();
		issue_command(OP_INS_POS, VAL_MIN, 5'd1);
		issue_command(OP_INS_FRONT, VAL_MAX, 5'd0);
		issue_command(OP_INS_BACK, 32'sd0, 5'd0);
		issue_command(OP_INS_POS, -32'sd1, 5'd3);
		issue_command(OP_INS_POS, 32'sd1, 5'd5);
		issue_command(OP_INS_POS, 32'sd2, 5'd7);
		issue_command(OP_DUMP, 32'sd0, 5'd0);
		issue_command(OP_DEL_POS, 32'sd0, 5'd5);
		issue_command(OP_DEL_POS, 32'sd0, 5'd5);
		issue_command(OP_DEL_POS, 32'sd0, 5'd2);
		issue_command(OP_UNUSED, 32'sd0, 5'd0);
		issue_command(OP_DEL_FRONT, 32'sd0, 5'd0);
		issue_command(OP_DUMP, 32'sd0, 5'd0);
		issue_command(OP_DEL_BACK, 32'sd0, 5'd0);
	endtask

	// Fills the list and tries every insert on it, then deletes at the far end.
	task automatic test_full_list();
		while (held_entries.size() < CAPACITY)
			issue_command(OP_INS_BACK, $urandom, 5'd0);
		issue_command(OP_INS_FRONT, VAL_MAX, 5'd0);
		issue_command(OP_INS_BACK, VAL_MIN, 5'd0);
		issue_command(OP_INS_POS, 32'sd5, 5'(CAPACITY + 1));
		issue_command(OP_INS_POS, 32'sd5, 5'(CAPACITY + 2));
		issue_command(OP_INS_POS, 32'sd5, 5'd31);
		issue_command(OP_DUMP, 32'sd0, 5'd0);
		issue_command(OP_DEL_POS, 32'sd0, 5'(CAPACITY));
		issue_command(OP_DEL_POS, 32'sd0, 5'(CAPACITY));
		issue_command(OP_INS_POS, VAL_MIN, 5'(CAPACITY - 1));
	endtask

	// Random commands that mostly keep to valid positions, with the list driven up to full
	// and back down to empty in turn.
	task automatic test_random_mix(input int n_items, input bit idle_sides, input bit vary_idle);
		bit growing;
		int roll;
		int n;
		logic [2:0] code;
		logic [4:0] pos;
		growing = 1'b1;
		send_idling = idle_sides;
		stall_idling = idle_sides;
		for (int k = 0; k < n_items; k++) begin
			if (vary_idle && k % 20 == 0) begin
				send_idling = $urandom_range(0, 1);
				stall_idling = $urandom_range(0, 1);
			end
			n = held_entries.size();
			if (n >= CAPACITY)
				growing = 1'b0;
			else if (n == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 29) == 0)
				growing = !growing;
			roll = $urandom_range(0, 99);
			if (roll < 9)
				code = OP_DUMP;
			else if (roll < 12)
				code = OP_UNUSED;
			else if (roll < (growing ? 72 : 38))
				code = 3'($urandom_range(OP_INS_FRONT, OP_INS_POS));
			else
				code = 3'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
			// Most positions fall inside the list; the rest are anything the field holds.
			if ($urandom_range(0, 4) == 0)
				pos = 5'($urandom_range(0, 31));
			else if (code == OP_INS_POS)
				pos = 5'($urandom_range(1, n + 1));
			else if (code == OP_DEL_POS && n > 0)
				pos = 5'($urandom_range(1, n));
			else
				pos = 5'($urandom_range(0, 31));
			issue_command(code, pick_value(), pos);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idling = 1'b1;
		stall_idling = 1'b1;
		test_empty_list();
		test_middle_updates();
		test_full_list();
		test_random_mix(130, 1'b1, 1'b0);
		test_random_mix(100, 1'b1, 1'b1);
		test_random_mix(80, 1'b0, 1'b0);
		in_valid <= 1'b0;

		// Drain the outstanding words, then watch for stray ones.
		for (int c = 0; c < 4000 && pending_results.size() != 0; c++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("result words never seen", 0, pending_results.size());

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
